// File: sv/dbk_pkg.sv
// shared types, mode codes and pixel arithmetic helpers for the edge line filter
package dbk_pkg;

    typedef logic [2:0] t_mode;

    // filter operation picked by the front end
    localparam t_mode MODE_NONE          = 3'd0;
    localparam t_mode MODE_LUMA_NORMAL   = 3'd1;
    localparam t_mode MODE_CHROMA_NORMAL = 3'd2;
    localparam t_mode MODE_LUMA_STRONG   = 3'd3;
    localparam t_mode MODE_EDGE_3TAP     = 3'd4;

    typedef struct packed {
        logic [31:0] p_px;
        logic [31:0] q_px;
        t_mode       mode;
        logic        ap_smooth;
        logic        aq_smooth;
        logic [4:0]  tc0;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // saturate a signed value to a pixel
    function automatic logic [7:0] sat8(input logic signed [12:0] v);
        logic [7:0] res;
        if (v < 13'sd0) begin
            res = 8'd0;
        end else if (v > 13'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // clip a signed value to +-t
    function automatic logic signed [12:0] clip_tc(input logic signed [12:0] v,
                                                   input logic [5:0] t);
        logic signed [12:0] tpos;
        logic signed [12:0] res;
        tpos = $signed({7'b0, t});
        if (v > tpos) begin
            res = tpos;
        end else if (v < -tpos) begin
            res = -tpos;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: sv/dbk_front.sv
// front end: accepts a pixel line and classifies it into a filter operation
module dbk_front (
    input  logic           i_valid,
    input  logic [31:0]    i_p_side,
    input  logic [31:0]    i_q_side,
    input  logic [7:0]     i_alpha_thr,
    input  logic [7:0]     i_beta_thr,
    input  logic [5:0]     i_clip_limit,
    input  logic           i_strong_mode,
    input  logic           i_is_chroma,
    input  dbk_pkg::t_q_stat i_q_stat,
    output logic           o_stall,
    output logic           o_push,
    output dbk_pkg::t_item o_item
);
    import dbk_pkg::*;

    logic [7:0] p0, p1, p2, q0, q1, q2;
    logic [7:0] ad_pq, ad_p10, ad_q10, ad_p20, ad_q20;
    logic [8:0] small_thr;
    logic       gate, skip, tc_neg, tc_zero, small_step;

    always_comb begin
        p0 = i_p_side[7:0];
        p1 = i_p_side[15:8];
        p2 = i_p_side[23:16];
        q0 = i_q_side[7:0];
        q1 = i_q_side[15:8];
        q2 = i_q_side[23:16];

        ad_pq  = abs_diff(p0, q0);
        ad_p10 = abs_diff(p1, p0);
        ad_q10 = abs_diff(q1, q0);
        ad_p20 = abs_diff(p2, p0);
        ad_q20 = abs_diff(q2, q0);

        gate = (ad_pq < i_alpha_thr) && (ad_p10 < i_beta_thr) && (ad_q10 < i_beta_thr);

        tc_neg  = i_clip_limit[5];
        tc_zero = (i_clip_limit == 6'd0);
        if (i_strong_mode) begin
            skip = 1'b0;
        end else if (i_is_chroma) begin
            skip = tc_neg || tc_zero;
        end else begin
            skip = tc_neg;
        end

        small_thr  = {3'b0, i_alpha_thr[7:2]} + 9'd2;
        small_step = ({1'b0, ad_pq} < small_thr);

        o_item.p_px      = i_p_side;
        o_item.q_px      = i_q_side;
        o_item.ap_smooth = (ad_p20 < i_beta_thr);
        o_item.aq_smooth = (ad_q20 < i_beta_thr);
        o_item.tc0       = i_clip_limit[4:0];

        if (skip || !gate) begin
            o_item.mode = MODE_NONE;
        end else if (!i_strong_mode) begin
            o_item.mode = i_is_chroma ? MODE_CHROMA_NORMAL : MODE_LUMA_NORMAL;
        end else if (!i_is_chroma && small_step) begin
            o_item.mode = MODE_LUMA_STRONG;
        end else begin
            o_item.mode = MODE_EDGE_3TAP;
        end

        o_stall = i_q_stat.full;
        o_push  = i_valid && !i_q_stat.full;
    end

endmodule

// File: sv/dbk_queue.sv
// short word queue between the classifier and the filter datapath
module dbk_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dbk_pkg::t_item   i_item,
    input  logic             i_pop,
    output dbk_pkg::t_item   o_head,
    output dbk_pkg::t_q_stat o_stat
);
    import dbk_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [IW-1:0] r_wr, n_wr;
    logic [IW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == FULL_CNT);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.empty || o_stat.full) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");

endmodule

// File: sv/dbk_back.sv
// back end: filter datapath and output register
module dbk_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dbk_pkg::t_item   i_head,
    input  dbk_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [31:0]      o_p_result,
    output logic [31:0]      o_q_result,
    output logic             o_was_filtered
);
    import dbk_pkg::*;

    logic               r_valid;
    logic [31:0]        r_p_result, r_q_result;
    logic               r_was_filtered;

    logic [7:0]         p0, p1, p2, p3, q0, q1, q2, q3;
    logic [8:0]         avg_sum, hp_sum, hq_sum;
    logic [7:0]         avg;
    logic signed [12:0] p0s, p1s, q0s, q1s, dp1, dq1, dsum, dedge, delta;
    logic [5:0]         tc0w, tc_luma, tc_sel;
    logic [7:0]         nm_p0, nm_q0, nm_p1, nm_q1;
    logic [10:0]        s_p0, s_p1, s_p2, s_q0, s_q1, s_q2, t_p0, t_q0;
    logic [7:0]         np0, np1, np2, nq0, nq1, nq2;
    logic               filt, load;

    always_comb begin
        p0 = i_head.p_px[7:0];
        p1 = i_head.p_px[15:8];
        p2 = i_head.p_px[23:16];
        p3 = i_head.p_px[31:24];
        q0 = i_head.q_px[7:0];
        q1 = i_head.q_px[15:8];
        q2 = i_head.q_px[23:16];
        q3 = i_head.q_px[31:24];

        p0s = $signed({5'b0, p0});
        p1s = $signed({5'b0, p1});
        q0s = $signed({5'b0, q0});
        q1s = $signed({5'b0, q1});

        // normal filter: side corrections and clipped edge delta
        avg_sum = {1'b0, p0} + {1'b0, q0} + 9'd1;
        avg     = avg_sum[8:1];
        hp_sum  = {1'b0, p2} + {1'b0, avg};
        hq_sum  = {1'b0, q2} + {1'b0, avg};
        dp1     = $signed({5'b0, hp_sum[8:1]}) - p1s;
        dq1     = $signed({5'b0, hq_sum[8:1]}) - q1s;
        tc0w    = {1'b0, i_head.tc0};
        nm_p1   = sat8(p1s + clip_tc(dp1, tc0w));
        nm_q1   = sat8(q1s + clip_tc(dq1, tc0w));
        tc_luma = tc0w + {5'b0, i_head.ap_smooth} + {5'b0, i_head.aq_smooth};
        tc_sel  = (i_head.mode == MODE_LUMA_NORMAL) ? tc_luma : tc0w;
        dsum    = ((q0s - p0s) <<< 2) + (p1s - q1s) + 13'sd4;
        dedge   = dsum >>> 3;
        delta   = clip_tc(dedge, tc_sel);
        nm_p0   = sat8(p0s + delta);
        nm_q0   = sat8(q0s - delta);

        // strong smoothing taps
        s_p0 = {3'b0, p2} + ({3'b0, p1} << 1) + ({3'b0, p0} << 1) + ({3'b0, q0} << 1)
             + {3'b0, q1} + 11'd4;
        s_p1 = {3'b0, p2} + {3'b0, p1} + {3'b0, p0} + {3'b0, q0} + 11'd2;
        s_p2 = ({3'b0, p3} << 1) + ({3'b0, p2} << 1) + {3'b0, p2} + {3'b0, p1}
             + {3'b0, p0} + {3'b0, q0} + 11'd4;
        s_q0 = {3'b0, p1} + ({3'b0, p0} << 1) + ({3'b0, q0} << 1) + ({3'b0, q1} << 1)
             + {3'b0, q2} + 11'd4;
        s_q1 = {3'b0, p0} + {3'b0, q0} + {3'b0, q1} + {3'b0, q2} + 11'd2;
        s_q2 = ({3'b0, q3} << 1) + ({3'b0, q2} << 1) + {3'b0, q2} + {3'b0, q1}
             + {3'b0, q0} + {3'b0, p0} + 11'd4;
        t_p0 = ({3'b0, p1} << 1) + {3'b0, p0} + {3'b0, q1} + 11'd2;
        t_q0 = ({3'b0, q1} << 1) + {3'b0, q0} + {3'b0, p1} + 11'd2;

        np0  = p0;
        np1  = p1;
        np2  = p2;
        nq0  = q0;
        nq1  = q1;
        nq2  = q2;
        filt = 1'b1;
        unique case (i_head.mode)
            MODE_LUMA_NORMAL: begin
                np0 = nm_p0;
                nq0 = nm_q0;
                if (i_head.ap_smooth) begin
                    np1 = nm_p1;
                end
                if (i_head.aq_smooth) begin
                    nq1 = nm_q1;
                end
            end
            MODE_CHROMA_NORMAL: begin
                np0 = nm_p0;
                nq0 = nm_q0;
            end
            MODE_LUMA_STRONG: begin
                if (i_head.ap_smooth) begin
                    np0 = s_p0[10:3];
                    np1 = s_p1[9:2];
                    np2 = s_p2[10:3];
                end else begin
                    np0 = t_p0[9:2];
                end
                if (i_head.aq_smooth) begin
                    nq0 = s_q0[10:3];
                    nq1 = s_q1[9:2];
                    nq2 = s_q2[10:3];
                end else begin
                    nq0 = t_q0[9:2];
                end
            end
            MODE_EDGE_3TAP: begin
                np0 = t_p0[9:2];
                nq0 = t_q0[9:2];
            end
            default: begin
                filt = 1'b0;
            end
        endcase

        load  = !i_q_stat.empty && (!r_valid || !i_stall);
        o_pop = load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_p_result     <= {p3, np2, np1, np0};
            r_q_result     <= {q3, nq2, nq1, nq0};
            r_was_filtered <= filt;
        end
    end

    assign o_valid        = r_valid;
    assign o_p_result     = r_p_result;
    assign o_q_result     = r_q_result;
    assign o_was_filtered = r_was_filtered;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_valid)
        else $error("loaded word not presented");

    a_skip_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_head.mode == MODE_NONE) |=> !r_was_filtered)
        else $error("skipped line marked as filtered");

endmodule

// File: sv/h264_deblock_edge_line_filter_unit.sv
// top level of the deblocking edge line filter: classifier, queue and filter datapath
//
// One input word is a line of eight pixels across a block edge (p3..p0, q0..q3)
// with its alpha, beta and tc0 thresholds and the strong/chroma mode bits.
// One output word carries the filtered p and q pixels and a filtered flag.
// Both channels use valid/stall: a word moves on a rising edge with valid high
// and stall low.
// Throughput: one line per cycle while the receiver does not stall, set by the
// combinational filter datapath feeding the output register.
// A line accepted into the queue is loaded from the queue head into the output
// register and is then offered on o_valid.
// When the receiver stalls the output register holds its word; the queue of
// QUEUE_DEPTH words keeps absorbing lines and o_stall rises only once it is full.
// Reset (i_rst_n low at a clock edge) empties the queue and drops o_valid.
module h264_deblock_edge_line_filter_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_p_side,
    input  logic [31:0] i_q_side,
    input  logic [7:0]  i_alpha_thr,
    input  logic [7:0]  i_beta_thr,
    input  logic [5:0]  i_clip_limit,
    input  logic        i_strong_mode,
    input  logic        i_is_chroma,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_p_result,
    output logic [31:0] o_q_result,
    output logic        o_was_filtered
);
    import dbk_pkg::*;

    t_item   push_item;
    t_item   head_item;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    dbk_front u_front (
        .i_valid       (i_valid),
        .i_p_side      (i_p_side),
        .i_q_side      (i_q_side),
        .i_alpha_thr   (i_alpha_thr),
        .i_beta_thr    (i_beta_thr),
        .i_clip_limit  (i_clip_limit),
        .i_strong_mode (i_strong_mode),
        .i_is_chroma   (i_is_chroma),
        .i_q_stat      (q_stat),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_item        (push_item)
    );

    dbk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (q_stat)
    );

    dbk_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_item),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_p_result     (o_p_result),
        .o_q_result     (o_q_result),
        .o_was_filtered (o_was_filtered)
    );

endmodule
